[rtl/sqltok_pkg.sv]
// Package for the SQL statement tokenizer: result record type, token kind codes,
// character classes and the keyword lookup. No dependencies.
package sqltok_pkg;

   localparam int TOKEN_BUFFER_SIZE_DEF = 256;
   localparam int STATEMENT_MAX_LEN_DEF = 4096;

   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int MAX_RESULTS = 4;

   localparam logic REC_VALUE = 1'b0;
   localparam logic REC_TOKEN = 1'b1;

   localparam logic [5:0] TK_END    = 6'd0;
   localparam logic [5:0] TK_WORD   = 6'd1;
   localparam logic [5:0] TK_INT    = 6'd2;
   localparam logic [5:0] TK_REAL   = 6'd3;
   localparam logic [5:0] TK_EQ     = 6'd4;
   localparam logic [5:0] TK_NE     = 6'd5;
   localparam logic [5:0] TK_LT     = 6'd6;
   localparam logic [5:0] TK_LE     = 6'd7;
   localparam logic [5:0] TK_GT     = 6'd8;
   localparam logic [5:0] TK_GE     = 6'd9;
   localparam logic [5:0] TK_LBRACE = 6'd10;
   localparam logic [5:0] TK_RBRACE = 6'd11;
   localparam logic [5:0] TK_SEP    = 6'd12;
   localparam logic [5:0] TK_STAR   = 6'd13;
   localparam logic [5:0] TK_QMARK  = 6'd14;

   typedef struct packed {
      logic       record_type;
      logic [7:0] value_byte;
      logic [5:0] token_kind;
      logic [11:0] token_start;
      logic [7:0] token_length;
      logic       last_of_run;
   } result_type;

   typedef struct packed {
      logic [3:0]      len;
      logic [8:0][7:0] text;   // text[8] is the first character
      logic [5:0]      kind;
   } keyword_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic keyword_type kw_entry(input logic [4:0] idx);
      keyword_type e;
      case (idx)
         5'd0:  e = '{4'd6, {"create", 24'h0}, 6'd15};
         5'd1:  e = '{4'd4, {"show", 40'h0}, 6'd16};
         5'd2:  e = '{4'd4, {"drop", 40'h0}, 6'd17};
         5'd3:  e = '{4'd3, {"use", 48'h0}, 6'd18};
         5'd4:  e = '{4'd6, {"insert", 24'h0}, 6'd19};
         5'd5:  e = '{4'd4, {"into", 40'h0}, 6'd20};
         5'd6:  e = '{4'd6, {"select", 24'h0}, 6'd21};
         5'd7:  e = '{4'd4, {"from", 40'h0}, 6'd22};
         5'd8:  e = '{4'd6, {"update", 24'h0}, 6'd23};
         5'd9:  e = '{4'd3, {"set", 48'h0}, 6'd24};
         5'd10: e = '{4'd5, {"where", 32'h0}, 6'd25};
         5'd11: e = '{4'd6, {"delete", 24'h0}, 6'd26};
         5'd12: e = '{4'd5, {"order", 32'h0}, 6'd27};
         5'd13: e = '{4'd2, {"by", 56'h0}, 6'd28};
         5'd14: e = '{4'd3, {"asc", 48'h0}, 6'd29};
         5'd15: e = '{4'd4, {"desc", 40'h0}, 6'd30};
         5'd16: e = '{4'd5, {"limit", 32'h0}, 6'd31};
         5'd17: e = '{4'd8, {"truncate", 8'h0}, 6'd32};
         5'd18: e = '{4'd8, {"database", 8'h0}, 6'd33};
         5'd19: e = '{4'd9, "databases", 6'd34};
         5'd20: e = '{4'd5, {"table", 32'h0}, 6'd35};
         5'd21: e = '{4'd6, {"tables", 24'h0}, 6'd36};
         5'd22: e = '{4'd3, {"int", 48'h0}, 6'd37};
         5'd23: e = '{4'd6, {"bigint", 24'h0}, 6'd37};
         5'd24: e = '{4'd4, {"bool", 40'h0}, 6'd38};
         5'd25: e = '{4'd4, {"text", 40'h0}, 6'd39};
         5'd26: e = '{4'd5, {"float", 32'h0}, 6'd40};
         5'd27: e = '{4'd9, "timestamp", 6'd41};
         5'd28: e = '{4'd4, {"true", 40'h0}, 6'd42};
         5'd29: e = '{4'd5, {"false", 32'h0}, 6'd43};
         default: e = '{4'd0, 72'h0, TK_WORD};
      endcase
      return e;
   endfunction

   // Case-insensitive whole-word match of the stored prefix.
   function automatic logic [5:0] kw_kind(input logic [8:0][7:0] prefix,
                                          input logic [3:0] len);
      logic [8:0][7:0] lc;
      logic [5:0]      kind;
      logic            hit;
      keyword_type     e;
      kind = TK_WORD;
      for (int j = 0; j < 9; j++) begin
         lc[j] = (prefix[j] >= "A" && prefix[j] <= "Z") ? prefix[j] + 8'd32 : prefix[j];
      end
      for (int i = 29; i >= 0; i--) begin
         e = kw_entry(5'(i));
         hit = (e.len == len);
         for (int j = 0; j < 9; j++) begin
            if (4'(j) < len && lc[j] != e.text[8 - j]) hit = 1'b0;
         end
         if (hit) kind = e.kind;
      end
      return kind;
   endfunction

   function automatic result_type mk_value(input logic [7:0] c);
      return '{REC_VALUE, c, 6'd0, 12'd0, 8'd0, 1'b0};
   endfunction

   function automatic result_type mk_token(input logic [5:0] kind, input logic [11:0] start,
                                           input logic [11:0] len);
      return '{REC_TOKEN, 8'd0, kind, start, (len > 12'd255) ? 8'hFF : len[7:0], 1'b0};
   endfunction

endpackage

[rtl/sqltok_req_if.sv]
// Input channel of the SQL statement tokenizer: one statement byte per transaction.
// No dependencies.
interface sqltok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

[rtl/sqltok_rsp_if.sv]
// Result channel of the SQL statement tokenizer: one value byte or token record per
// transaction. No dependencies.
interface sqltok_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_type;
   logic [7:0]  value_byte;
   logic [5:0]  token_kind;
   logic [11:0] token_start;
   logic [7:0]  token_length;
   logic        last_of_run;

   modport source (output valid, output record_type, output value_byte, output token_kind,
                   output token_start, output token_length, output last_of_run, input ready);
   modport sink (input valid, input record_type, input value_byte, input token_kind,
                 input token_start, input token_length, input last_of_run, output ready);
endinterface

[rtl/sql_statement_tokenizer_unit.sv]
// SQL statement tokenizer top level: lexer state, per-byte lexing logic, result queue.
// Depends on sqltok_pkg, sqltok_req_if, sqltok_rsp_if and sqltok_rsp_queue.
//
// One statement byte is accepted per clock while the eight-entry result queue has room
// for four results; a byte yields zero to four results, which leave at one per cycle
// while rsp_ch is ready. Lexing of a byte, including the look-back on a held exponent
// and the keyword compare against all thirty keywords, completes in the cycle it is
// accepted, so the sustained rate is one byte per cycle, bounded by the result drain.
module sql_statement_tokenizer_unit #(
   parameter int TOKEN_BUFFER_SIZE = sqltok_pkg::TOKEN_BUFFER_SIZE_DEF,
   parameter int STATEMENT_MAX_LEN = sqltok_pkg::STATEMENT_MAX_LEN_DEF
) (
   input logic          clock,
   input logic          reset,
   sqltok_req_if.sink   req_ch,
   sqltok_rsp_if.source rsp_ch
);
   localparam int LEN_W = $clog2(TOKEN_BUFFER_SIZE);
   localparam logic [LEN_W-1:0] TOK_CAP = LEN_W'(TOKEN_BUFFER_SIZE - 1);
   localparam logic [11:0] POS_LIMIT =
      (STATEMENT_MAX_LEN - 1 < 4095) ? 12'(STATEMENT_MAX_LEN - 1) : 12'd4095;

   typedef enum logic [3:0] {
      M_IDLE, M_WORD, M_INT, M_FRAC, M_EXPP, M_EXP, M_STR, M_STRQ, M_CAPT,
      M_LT, M_GT, M_BANG, M_DROP
   } mode_type;

   typedef struct packed {
      mode_type         mode;
      logic [8:0][7:0]  prefix;
      logic             too_long;
      logic             quote;
      logic             real_num;
      logic             pend2;
      logic [1:0][7:0]  pend;
      logic [11:0]      start;
      logic [LEN_W-1:0] len;
      logic [11:0]      offset;
   } lex_type;

   lex_type                st_ff, st_in;
   sqltok_pkg::result_type res_in [sqltok_pkg::MAX_RESULTS];
   logic [2:0]             res_cnt;
   logic                   accept, pop, has_room, not_empty;
   sqltok_pkg::result_type head;

   assign accept       = req_ch.valid & req_ch.ready;
   assign req_ch.ready = has_room;
   assign pop          = rsp_ch.valid & rsp_ch.ready;

   always_comb begin
      lex_type     s;
      logic [7:0]  c, qc;
      logic [11:0] pos, epos;
      logic [2:0]  cnt;
      logic        go, done;
      logic [5:0]  kind;

      s    = st_ff;
      c    = req_ch.text_byte;
      pos  = st_ff.offset;
      cnt  = 3'd0;
      go   = 1'b1;
      done = 1'b0;
      kind = sqltok_pkg::TK_WORD;
      for (int i = 0; i < sqltok_pkg::MAX_RESULTS; i++) res_in[i] = '0;

      // held exponent letter and sign
      if (s.mode == M_EXPP) begin
         go = 1'b0;
         if (!s.pend2 && (c == "+" || c == "-")) begin
            s.pend[1] = c;
            s.pend2   = 1'b1;
         end else if (sqltok_pkg::is_digit(c)) begin
            s.real_num = 1'b1;
            s.mode     = M_EXP;
            res_in[cnt[1:0]] = sqltok_pkg::mk_value(s.pend[0]);
            cnt   = cnt + 3'd1;
            s.len = s.len + LEN_W'(1);
            if (s.len >= TOK_CAP) begin
               res_in[cnt[1:0]] = sqltok_pkg::mk_token(sqltok_pkg::TK_REAL, s.start, 12'(s.len));
               cnt = cnt + 3'd1;
               go  = 1'b1;
               s.mode = M_IDLE;
            end else if (s.pend2) begin
               res_in[cnt[1:0]] = sqltok_pkg::mk_value(s.pend[1]);
               cnt   = cnt + 3'd1;
               s.len = s.len + LEN_W'(1);
               if (s.len >= TOK_CAP) begin
                  res_in[cnt[1:0]] =
                     sqltok_pkg::mk_token(sqltok_pkg::TK_REAL, s.start, 12'(s.len));
                  cnt = cnt + 3'd1;
                  go  = 1'b1;
                  s.mode = M_IDLE;
               end
            end
            if (!go) begin
               res_in[cnt[1:0]] = sqltok_pkg::mk_value(c);
               cnt   = cnt + 3'd1;
               s.len = s.len + LEN_W'(1);
               if (s.len >= TOK_CAP) begin
                  res_in[cnt[1:0]] =
                     sqltok_pkg::mk_token(sqltok_pkg::TK_REAL, s.start, 12'(s.len));
                  cnt = cnt + 3'd1;
                  s.mode = M_IDLE;
               end
            end
            // a digit left over after a cap starts a new number below
         end else begin
            res_in[cnt[1:0]] = sqltok_pkg::mk_token(
               s.real_num ? sqltok_pkg::TK_REAL : sqltok_pkg::TK_INT, s.start, 12'(s.len));
            cnt  = cnt + 3'd1;
            epos = s.pend2 ? ((pos >= 12'd2) ? pos - 12'd2 : 12'd0)
                           : ((pos >= 12'd1) ? pos - 12'd1 : 12'd0);
            s.start     = epos;
            s.len       = LEN_W'(1);
            s.too_long  = 1'b0;
            s.prefix[0] = s.pend[0];
            res_in[cnt[1:0]] = sqltok_pkg::mk_value(s.pend[0]);
            cnt    = cnt + 3'd1;
            s.mode = M_WORD;
            if (s.pend2) begin
               res_in[cnt[1:0]] = sqltok_pkg::mk_token(sqltok_pkg::TK_WORD, epos, 12'd1);
               cnt    = cnt + 3'd1;
               s.mode = M_IDLE;
            end
            go = 1'b1;
         end
      end

      for (int p = 0; p < 2; p++) begin
         if (go) begin
            go = 1'b0;
            qc = s.quote ? 8'h27 : 8'h22;
            unique case (s.mode)
               M_IDLE: begin
                  if (c == 8'd0) begin
                     res_in[cnt[1:0]] = sqltok_pkg::mk_token(sqltok_pkg::TK_END, pos, 12'd1);
                     cnt  = cnt + 3'd1;
                     done = 1'b1;
                  end else if (c == ";") begin
                     res_in[cnt[1:0]] = sqltok_pkg::mk_token(sqltok_pkg::TK_END, pos, 12'd1);
                     cnt    = cnt + 3'd1;
                     s.mode = M_DROP;
                  end else if (c == 8'h22 || c == 8'h27) begin
                     s.quote = (c == 8'h27);
                     s.start = (pos < POS_LIMIT) ? pos + 12'd1 : POS_LIMIT;
                     s.len   = '0;
                     s.mode  = M_STR;
                  end else if (sqltok_pkg::is_alpha(c)) begin
                     s.start     = pos;
                     s.len       = LEN_W'(1);
                     s.too_long  = 1'b0;
                     s.prefix[0] = c;
                     res_in[cnt[1:0]] = sqltok_pkg::mk_value(c);
                     cnt    = cnt + 3'd1;
                     s.mode = M_WORD;
                  end else if (sqltok_pkg::is_digit(c)) begin
                     s.start    = pos;
                     s.len      = LEN_W'(1);
                     s.real_num = 1'b0;
                     res_in[cnt[1:0]] = sqltok_pkg::mk_value(c);
                     cnt    = cnt + 3'd1;
                     s.mode = M_INT;
                  end else begin
                     s.start = pos;
                     kind    = sqltok_pkg::TK_END;
                     case (c)
                        "=": kind = sqltok_pkg::TK_EQ;
                        "{": kind = sqltok_pkg::TK_LBRACE;
                        "}": kind = sqltok_pkg::TK_RBRACE;
                        ",": kind = sqltok_pkg::TK_SEP;
                        "*": kind = sqltok_pkg::TK_STAR;
                        "?": kind = sqltok_pkg::TK_QMARK;
                        "!": s.mode = M_BANG;
                        "<": s.mode = M_LT;
                        ">": s.mode = M_GT;
                        default: kind = sqltok_pkg::TK_END;
                     endcase
                     if (kind != sqltok_pkg::TK_END) begin
                        res_in[cnt[1:0]] = sqltok_pkg::mk_token(kind, pos, 12'd1);
                        cnt = cnt + 3'd1;
                     end
                  end
               end
               M_WORD: begin
                  if (sqltok_pkg::is_alpha(c) || sqltok_pkg::is_digit(c)) begin
                     if (s.len < LEN_W'(9)) s.prefix[s.len[3:0]] = c;
                     else s.too_long = 1'b1;
                     res_in[cnt[1:0]] = sqltok_pkg::mk_value(c);
                     cnt   = cnt + 3'd1;
                     s.len = s.len + LEN_W'(1);
                     if (s.len >= TOK_CAP) begin
                        res_in[cnt[1:0]] =
                           sqltok_pkg::mk_token(sqltok_pkg::TK_WORD, s.start, 12'(s.len));
                        cnt    = cnt + 3'd1;
                        s.mode = M_IDLE;
                     end
                  end else begin
                     kind = (c == "_" || s.too_long) ? sqltok_pkg::TK_WORD
                                                    : sqltok_pkg::kw_kind(s.prefix, s.len[3:0]);
                     res_in[cnt[1:0]] = sqltok_pkg::mk_token(kind, s.start, 12'(s.len));
                     cnt    = cnt + 3'd1;
                     s.mode = M_IDLE;
                     go     = 1'b1;
                  end
               end
               M_INT, M_FRAC, M_EXP: begin
                  if (sqltok_pkg::is_digit(c) || (c == "." && s.mode == M_INT)) begin
                     if (c == ".") begin
                        s.real_num = 1'b1;
                        s.mode     = M_FRAC;
                     end
                     res_in[cnt[1:0]] = sqltok_pkg::mk_value(c);
                     cnt   = cnt + 3'd1;
                     s.len = s.len + LEN_W'(1);
                     if (s.len >= TOK_CAP) begin
                        res_in[cnt[1:0]] = sqltok_pkg::mk_token(
                           s.real_num ? sqltok_pkg::TK_REAL : sqltok_pkg::TK_INT,
                           s.start, 12'(s.len));
                        cnt    = cnt + 3'd1;
                        s.mode = M_IDLE;
                     end
                  end else if ((c == "e" || c == "E") && s.mode != M_EXP) begin
                     s.pend[0] = c;
                     s.pend2   = 1'b0;
                     s.mode    = M_EXPP;
                  end else begin
                     res_in[cnt[1:0]] = sqltok_pkg::mk_token(
                        s.real_num ? sqltok_pkg::TK_REAL : sqltok_pkg::TK_INT,
                        s.start, 12'(s.len));
                     cnt    = cnt + 3'd1;
                     s.mode = M_IDLE;
                     go     = 1'b1;
                  end
               end
               M_STR, M_STRQ: begin
                  if (s.mode == M_STR && c == 8'd0) begin
                     res_in[cnt[1:0]] =
                        sqltok_pkg::mk_token(sqltok_pkg::TK_WORD, s.start, 12'(s.len));
                     cnt    = cnt + 3'd1;
                     s.mode = M_IDLE;
                     go     = 1'b1;
                  end else if (s.mode == M_STR && c == qc) begin
                     s.mode = M_STRQ;
                  end else if (s.mode == M_STRQ && c != qc) begin
                     res_in[cnt[1:0]] =
                        sqltok_pkg::mk_token(sqltok_pkg::TK_WORD, s.start, 12'(s.len));
                     cnt    = cnt + 3'd1;
                     s.mode = M_IDLE;
                     go     = 1'b1;
                  end else begin
                     res_in[cnt[1:0]] = sqltok_pkg::mk_value(c);
                     cnt    = cnt + 3'd1;
                     s.len  = s.len + LEN_W'(1);
                     s.mode = M_STR;
                     if (s.len >= TOK_CAP) begin
                        res_in[cnt[1:0]] =
                           sqltok_pkg::mk_token(sqltok_pkg::TK_WORD, s.start, 12'(s.len));
                        cnt    = cnt + 3'd1;
                        s.mode = M_CAPT;
                     end
                  end
               end
               M_CAPT: begin
                  s.mode = M_IDLE;
                  go     = (c != qc);
               end
               M_LT, M_GT: begin
                  kind   = (s.mode == M_LT) ? sqltok_pkg::TK_LT : sqltok_pkg::TK_GT;
                  s.mode = M_IDLE;
                  if (c == "=") begin
                     res_in[cnt[1:0]] = sqltok_pkg::mk_token(
                        (kind == sqltok_pkg::TK_LT) ? sqltok_pkg::TK_LE : sqltok_pkg::TK_GE,
                        s.start, 12'd2);
                  end else begin
                     res_in[cnt[1:0]] = sqltok_pkg::mk_token(kind, s.start, 12'd1);
                     go = 1'b1;
                  end
                  cnt = cnt + 3'd1;
               end
               M_BANG: begin
                  s.mode = M_IDLE;
                  if (c == "=") begin
                     res_in[cnt[1:0]] = sqltok_pkg::mk_token(sqltok_pkg::TK_NE, s.start, 12'd2);
                     cnt = cnt + 3'd1;
                  end else begin
                     go = 1'b1;
                  end
               end
               M_DROP: begin
                  if (c == 8'd0) begin
                     s.mode = M_IDLE;
                     done   = 1'b1;
                  end
               end
               default: begin
                  s.mode = M_IDLE;
                  go     = 1'b1;
               end
            endcase
         end
      end

      for (int i = 0; i < sqltok_pkg::MAX_RESULTS; i++) begin
         res_in[i].last_of_run = (3'(i + 1) == cnt);
      end

      s.offset = done ? 12'd0 : ((pos < POS_LIMIT) ? pos + 12'd1 : POS_LIMIT);
      st_in    = s;
      res_cnt  = cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.mode     <= M_IDLE;
         st_ff.too_long <= 1'b0;
         st_ff.quote    <= 1'b0;
         st_ff.real_num <= 1'b0;
         st_ff.pend2    <= 1'b0;
         st_ff.start    <= '0;
         st_ff.len      <= '0;
         st_ff.offset   <= '0;
      end else if (accept) begin
         st_ff <= st_in;
      end
   end

   sqltok_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (accept ? res_cnt : 3'd0),
      .push_data (res_in),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .has_room  (has_room)
   );

   assign rsp_ch.valid        = not_empty;
   assign rsp_ch.record_type  = head.record_type;
   assign rsp_ch.value_byte   = head.value_byte;
   assign rsp_ch.token_kind   = head.token_kind;
   assign rsp_ch.token_start  = head.token_start;
   assign rsp_ch.token_length = head.token_length;
   assign rsp_ch.last_of_run  = head.last_of_run;
endmodule

[rtl/sqltok_rsp_queue.sv]
// Result queue: takes up to four results per cycle, hands out one per cycle when popped.
// Depends on sqltok_pkg.
module sqltok_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             push_cnt,
   input  sqltok_pkg::result_type push_data [sqltok_pkg::MAX_RESULTS],
   input  logic                   pop,
   output sqltok_pkg::result_type head,
   output logic                   not_empty,
   output logic                   has_room
);
   localparam int PW = sqltok_pkg::QUEUE_PTR_W;

   sqltok_pkg::result_type mem [sqltok_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   assign not_empty = count_ff != '0;
   assign has_room  = count_ff <= (PW + 1)'(sqltok_pkg::QUEUE_DEPTH - sqltok_pkg::MAX_RESULTS);
   assign head      = mem[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + PW'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign count_in  = count_ff + (PW + 1)'(push_cnt) - (PW + 1)'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < sqltok_pkg::MAX_RESULTS; i++) begin
         if (3'(i) < push_cnt) mem[wr_ptr_ff + PW'(i)] <= push_data[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
